// ----- hdl/svm_pkg.sv -----
// Shared constants, types and register codes of the stereo voice mixer.
// No dependencies; imported by every module of the block.
package svm_pkg;

  // voice count
  localparam int MAX_VOICES     = 3;
  localparam int DEF_NUM_VOICES = 3;

  // field widths
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int VOICE_W = 2;
  localparam int REG_IW  = 3;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 32;

  // register codes
  localparam logic [REG_IW-1:0] REG_MASTER = 3'd0;
  localparam int                REG_GAIN0  = 1;
  localparam int                REG_PAN0   = 4;

  // value limits
  localparam int GAIN_MAX   = 32768;
  localparam int GAIN_RESET = 16384;
  localparam int PAN_MAX    = 16384;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // shared multiplier: 32 x 16 unsigned, 48-bit product
  localparam int MUL_AW  = 32;
  localparam int MUL_BW  = 16;
  localparam int MUL_PW  = 48;
  localparam int MAC_SH  = 16;
  localparam int T_W     = 46;  // gain * master * amp factor
  localparam int FRAC_SH = 27;  // remaining shift after the split product
  localparam int SCL_W   = 18;  // scaled magnitude, up to 2^17

  typedef struct packed {
    logic              en;
    logic              mac;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_cmd_t;

endpackage

// ----- hdl/stereo_voice_mixer_pan_gain.sv -----
// Top level of the stereo voice mixer with per-voice gain and linear pan.
// Depends on svm_pkg, svm_cfg, svm_ctrl and svm_mul.
//
// Usage: one input beat carries one stereo sample of one voice. It is scaled
// by the voice gain and the master gain (Q2.14), panned linearly and added,
// with saturation to 16 bits, into the frame accumulator. A beat with in_tlast
// set closes the frame: the accumulated pair leaves as one output beat and the
// accumulator clears. A voice index at or above NUM_VOICES adds nothing, but
// its in_tlast still closes the frame.
// Timing: every product runs through one shared 32 x 16 multiplier, seven
// passes per beat (gain x master, then amp factor and a split sample product
// for each side). A valid voice holds in_tready low until the sequencer has run
// its passes and the right accumulate, so no beat is taken while one is mixed; a
// closing beat then passes an output load state, which waits while an earlier
// result stalls; out_tvalid rises after the load. Absent voices skip the passes.
// Stall: the result sits in an output register; the next frame is mixed
// meanwhile and only its own load waits for out_tready.
// Reset (rst_n low, synchronous) clears the accumulator and output valid and
// returns gains to unity and pans to centre. Config beats are always taken
// and should be written only while the block is idle.
module stereo_voice_mixer_pan_gain #(
  parameter int NUM_VOICES = svm_pkg::DEF_NUM_VOICES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // voice[1:0], sample_left[17:2], sample_right[33:18], zero pad[39:34]
  input  logic [svm_pkg::IN_DW-1:0]     in_tdata,
  input  logic                          in_tlast,   // last_voice
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // mixed_left[15:0], mixed_right[31:16]
  output logic [svm_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [svm_pkg::REG_IW-1:0]    cfg_index,
  input  logic [svm_pkg::GAIN_W-1:0]    cfg_data
);
  import svm_pkg::*;

  logic [GAIN_W-1:0]                 main_gain;
  logic [NUM_VOICES-1:0][GAIN_W-1:0] gains;
  logic [NUM_VOICES-1:0][GAIN_W-1:0] pans;
  mul_cmd_t                          mul_cmd;
  logic [MUL_PW-1:0]                 mul_p;

  // register file
  svm_cfg #(.NUM_VOICES(NUM_VOICES)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .main_gain   (main_gain),
    .gains       (gains),
    .pans        (pans)
  );

  // sequencer, accumulators, output register
  svm_ctrl #(.NUM_VOICES(NUM_VOICES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .main_gain   (main_gain),
    .gains       (gains),
    .pans        (pans),
    .mul_cmd     (mul_cmd),
    .mul_p       (mul_p)
  );

  // shared multiplier, product registered
  svm_mul u_mul (
    .clk (clk),
    .cmd (mul_cmd),
    .p   (mul_p)
  );

endmodule

// ----- hdl/svm_mul.sv -----
// Shared multiply / multiply-accumulate unit of the mixer.
// Depends on svm_pkg.
module svm_mul (
  input  logic              clk,
  input  svm_pkg::mul_cmd_t cmd,
  output logic [svm_pkg::MUL_PW-1:0] p
);
  import svm_pkg::*;

  logic [MUL_PW-1:0] p_r;
  logic [MUL_PW-1:0] p_nxt;
  logic [MUL_PW-1:0] prod;

  always_comb begin
    prod  = MUL_PW'(cmd.a) * MUL_PW'(cmd.b);
    p_nxt = p_r;
    if (cmd.en) begin
      // mac folds in the low partial product, already scaled down
      p_nxt = cmd.mac ? prod + (p_r >> MAC_SH) : prod;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

// ----- hdl/svm_cfg.sv -----
// Configuration registers: master gain, per-voice gain and pan, with clamping.
// Depends on svm_pkg.
module svm_cfg #(
  parameter int NUM_VOICES = svm_pkg::DEF_NUM_VOICES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [svm_pkg::REG_IW-1:0]             cfg_index,
  input  logic [svm_pkg::GAIN_W-1:0]             cfg_data,
  output logic [svm_pkg::GAIN_W-1:0]             main_gain,
  output logic [NUM_VOICES-1:0][svm_pkg::GAIN_W-1:0] gains,
  output logic [NUM_VOICES-1:0][svm_pkg::GAIN_W-1:0] pans
);
  import svm_pkg::*;

  logic [GAIN_W-1:0]                  master_r, master_nxt;
  logic [NUM_VOICES-1:0][GAIN_W-1:0]  gain_r, gain_nxt;
  logic [NUM_VOICES-1:0][GAIN_W-1:0]  pan_r, pan_nxt;
  logic [GAIN_W-1:0]                  gain_clamp;
  logic signed [GAIN_W-1:0]           pan_clamp;
  logic                               wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_comb begin
    gain_clamp = (cfg_data > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : cfg_data;
    pan_clamp  = $signed(cfg_data);
    if ($signed(cfg_data) > $signed(GAIN_W'(PAN_MAX))) begin
      pan_clamp = GAIN_W'(PAN_MAX);
    end else if ($signed(cfg_data) < -$signed(GAIN_W'(PAN_MAX))) begin
      pan_clamp = -$signed(GAIN_W'(PAN_MAX));
    end

    master_nxt = master_r;
    gain_nxt   = gain_r;
    pan_nxt    = pan_r;
    if (wr) begin
      if (cfg_index == REG_MASTER) begin
        master_nxt = gain_clamp;
      end
      // writes to voices beyond NUM_VOICES are dropped: those voices are silent
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (cfg_index == REG_IW'(REG_GAIN0 + i)) begin
          gain_nxt[i] = gain_clamp;
        end
        if (cfg_index == REG_IW'(REG_PAN0 + i)) begin
          pan_nxt[i] = pan_clamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= GAIN_W'(GAIN_RESET);
      for (int i = 0; i < NUM_VOICES; i++) begin
        gain_r[i] <= GAIN_W'(GAIN_RESET);
        pan_r[i]  <= '0;
      end
    end else begin
      master_r <= master_nxt;
      gain_r   <= gain_nxt;
      pan_r    <= pan_nxt;
    end
  end

  assign main_gain = master_r;
  assign gains     = gain_r;
  assign pans      = pan_r;

endmodule

// ----- hdl/svm_ctrl.sv -----
// Sequencer of the mixer: drives the shared multiplier, holds the frame
// accumulators and the output register. Depends on svm_pkg.
module svm_ctrl #(
  parameter int NUM_VOICES = svm_pkg::DEF_NUM_VOICES
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [svm_pkg::IN_DW-1:0]                  in_tdata,
  input  logic                                       in_tlast,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [svm_pkg::OUT_DW-1:0]                 out_tdata,
  input  logic [svm_pkg::GAIN_W-1:0]                 main_gain,
  input  logic [NUM_VOICES-1:0][svm_pkg::GAIN_W-1:0] gains,
  input  logic [NUM_VOICES-1:0][svm_pkg::GAIN_W-1:0] pans,
  output svm_pkg::mul_cmd_t                          mul_cmd,
  input  logic [svm_pkg::MUL_PW-1:0]                 mul_p
);
  import svm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GM   = 4'd1;
  localparam logic [3:0] ST_LF   = 4'd2;
  localparam logic [3:0] ST_LLO  = 4'd3;
  localparam logic [3:0] ST_LHI  = 4'd4;
  localparam logic [3:0] ST_LACC = 4'd5;
  localparam logic [3:0] ST_RLO  = 4'd6;
  localparam logic [3:0] ST_RHI  = 4'd7;
  localparam logic [3:0] ST_RACC = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  function automatic logic signed [SMP_W-1:0] acc_add(
    input logic signed [SMP_W-1:0] acc,
    input logic                    neg,
    input logic [SCL_W-1:0]        mag
  );
    logic signed [SCL_W+1:0] term;
    logic signed [SCL_W+1:0] sum;
    logic signed [SMP_W-1:0] res;
    term = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum  = term + (SCL_W+2)'(acc);
    res  = acc;
    if (sum > (SCL_W+2)'(SAMPLE_MAX)) begin
      res = SMP_W'(SAMPLE_MAX);
    end else if (sum < (SCL_W+2)'(SAMPLE_MIN)) begin
      res = SMP_W'(SAMPLE_MIN);
    end else begin
      res = sum[SMP_W-1:0];
    end
    return res;
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic                    last_r, last_nxt;
  logic [GAIN_W-1:0]       gsel_r, gsel_nxt;
  logic [MUL_BW-1:0]       fl_r, fl_nxt;
  logic [MUL_BW-1:0]       fr_r, fr_nxt;
  logic [SMP_W-1:0]        mag_l_r, mag_l_nxt;
  logic [SMP_W-1:0]        mag_r_r, mag_r_nxt;
  logic                    neg_l_r, neg_l_nxt;
  logic                    neg_r_r, neg_r_nxt;
  logic [T_W-MAC_SH-1:0]   thi_r, thi_nxt;
  logic [MUL_AW-2:0]       gm_r, gm_nxt;
  logic signed [SMP_W-1:0] acc_l_r, acc_l_nxt;
  logic signed [SMP_W-1:0] acc_r_r, acc_r_nxt;
  logic                    ov_r, ov_nxt;
  logic [OUT_DW-1:0]       od_r, od_nxt;

  logic [VOICE_W-1:0]      in_voice;
  logic signed [SMP_W-1:0] in_sl, in_sr;
  logic                    vok;
  logic [GAIN_W-1:0]       gsel;
  logic signed [SMP_W:0]   pan_x;
  logic [SCL_W-1:0]        scaled;

  assign in_voice = in_tdata[VOICE_W-1:0];
  assign in_sl    = $signed(in_tdata[VOICE_W+SMP_W-1:VOICE_W]);
  assign in_sr    = $signed(in_tdata[VOICE_W+2*SMP_W-1:VOICE_W+SMP_W]);
  assign scaled   = mul_p[FRAC_SH+SCL_W-1:FRAC_SH];
  assign in_tready = (state_r == ST_IDLE);

  // voice lookup
  always_comb begin
    vok   = 1'b0;
    gsel  = '0;
    pan_x = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (in_voice == VOICE_W'(i)) begin
        vok   = 1'b1;
        gsel  = gains[i];
        pan_x = (SMP_W+1)'($signed(pans[i]));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    gsel_nxt  = gsel_r;
    fl_nxt    = fl_r;
    fr_nxt    = fr_r;
    mag_l_nxt = mag_l_r;
    mag_r_nxt = mag_r_r;
    neg_l_nxt = neg_l_r;
    neg_r_nxt = neg_r_r;
    thi_nxt   = thi_r;
    gm_nxt    = gm_r;
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    mul_cmd   = '0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_tlast;
          gsel_nxt  = gsel;
          fl_nxt    = MUL_BW'((SMP_W+1)'(PAN_MAX) - pan_x);
          fr_nxt    = MUL_BW'(pan_x + (SMP_W+1)'(PAN_MAX));
          neg_l_nxt = in_sl[SMP_W-1];
          neg_r_nxt = in_sr[SMP_W-1];
          mag_l_nxt = in_sl[SMP_W-1] ? SMP_W'(-in_sl) : SMP_W'(in_sl);
          mag_r_nxt = in_sr[SMP_W-1] ? SMP_W'(-in_sr) : SMP_W'(in_sr);
          if (vok) begin
            state_nxt = ST_GM;
          end else if (in_tlast) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_GM: begin
        mul_cmd = '{en: 1'b1, mac: 1'b0, a: MUL_AW'(gsel_r), b: main_gain};
        state_nxt = ST_LF;
      end
      ST_LF: begin
        gm_nxt  = mul_p[MUL_AW-2:0];
        mul_cmd = '{en: 1'b1, mac: 1'b0, a: mul_p[MUL_AW-1:0], b: fl_r};
        state_nxt = ST_LLO;
      end
      ST_LLO: begin
        thi_nxt = mul_p[T_W-1:MAC_SH];
        mul_cmd = '{en: 1'b1, mac: 1'b0, a: MUL_AW'(mul_p[MAC_SH-1:0]), b: mag_l_r};
        state_nxt = ST_LHI;
      end
      ST_LHI: begin
        mul_cmd = '{en: 1'b1, mac: 1'b1, a: MUL_AW'(thi_r), b: mag_l_r};
        state_nxt = ST_LACC;
      end
      ST_LACC: begin
        acc_l_nxt = acc_add(acc_l_r, neg_l_r, scaled);
        mul_cmd   = '{en: 1'b1, mac: 1'b0, a: MUL_AW'(gm_r), b: fr_r};
        state_nxt = ST_RLO;
      end
      ST_RLO: begin
        thi_nxt = mul_p[T_W-1:MAC_SH];
        mul_cmd = '{en: 1'b1, mac: 1'b0, a: MUL_AW'(mul_p[MAC_SH-1:0]), b: mag_r_r};
        state_nxt = ST_RHI;
      end
      ST_RHI: begin
        mul_cmd = '{en: 1'b1, mac: 1'b1, a: MUL_AW'(thi_r), b: mag_r_r};
        state_nxt = ST_RACC;
      end
      ST_RACC: begin
        acc_r_nxt = acc_add(acc_r_r, neg_r_r, scaled);
        state_nxt = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = {acc_r_r, acc_l_r};
          acc_l_nxt = '0;
          acc_r_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_l_r <= '0;
      acc_r_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    gsel_r  <= gsel_nxt;
    fl_r    <= fl_nxt;
    fr_r    <= fr_nxt;
    mag_l_r <= mag_l_nxt;
    mag_r_r <= mag_r_nxt;
    neg_l_r <= neg_l_nxt;
    neg_r_r <= neg_r_nxt;
    thi_r   <= thi_nxt;
    gm_r    <= gm_nxt;
    od_r    <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// ----- hdl/svm_chk.sv -----
// Port-level checker for the stereo voice mixer, bound to the top level.
// Depends on stereo_voice_mixer_pan_gain.
module svm_chk #(
  parameter int NUM_VOICES = svm_pkg::DEF_NUM_VOICES
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [svm_pkg::IN_DW-1:0]  in_tdata,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [svm_pkg::OUT_DW-1:0] out_tdata,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [svm_pkg::REG_IW-1:0] cfg_index,
  input logic [svm_pkg::GAIN_W-1:0] cfg_data
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // a present voice keeps the sequencer busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (32'(in_tdata[1:0]) < NUM_VOICES) |=> !in_tready)
    else $error("input taken again while a voice is being mixed");

  // a frame is loaded only while the input side is held off
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("output loaded outside frame close");

endmodule

bind stereo_voice_mixer_pan_gain svm_chk #(.NUM_VOICES(NUM_VOICES)) u_svm_chk (.*);

// ----- test/stereo_voice_mixer_pan_gain_tb.sv -----
// Self-checking testbench for stereo_voice_mixer_pan_gain: directed and random voice beats
// checked against a bit-exact gain, pan and saturation predictor. Depends on svm_pkg and stereo_voice_mixer_pan_gain.
module stereo_voice_mixer_pan_gain_tb;
  import svm_pkg::*;

  localparam int              NUM_V        = DEF_NUM_VOICES;
  localparam int              AMP_ONE      = 32768;
  localparam logic [REG_IW-1:0] REG_SPARE  = 3'd7;    // unmapped index, write is dropped
  localparam logic [VOICE_W-1:0] VOICE_ABSENT = 2'd3; // beyond NUM_VOICES, adds nothing
  localparam int              SETTLE       = 12;      // settling wait for a trailing beat, with margin
  localparam int              CYCLE_LIMIT  = 400000;
  localparam int              RAND_PHASES  = 8;
  localparam int              PHASE_BEATS  = 150;

  typedef struct {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } frame_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DW-1:0]      in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DW-1:0]     out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [REG_IW-1:0]     cfg_index;
  logic [GAIN_W-1:0]     cfg_data;

  // predictor state: registers as the block holds them after clamping
  logic [GAIN_W-1:0]        master_q;
  logic [GAIN_W-1:0]        gain_q [NUM_V];
  logic signed [GAIN_W-1:0] pan_q  [NUM_V];
  logic signed [SMP_W-1:0]  acc_l;
  logic signed [SMP_W-1:0]  acc_r;

  frame_t pending_frames[$];
  int     fails;
  int     cycles = 0;
  bit     send_idle;
  bit     drain_idle;

  stereo_voice_mixer_pan_gain #(.NUM_VOICES(NUM_V)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stereo_voice_mixer_pan_gain test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // sample * gain * master * amp factor, exact in 64 bits, back to Q1.15 toward zero
  function automatic longint pan_scale(logic signed [SMP_W-1:0] smp, longint g, longint m,
                                       longint f);
    longint p;
    p = longint'(smp) * g * m * f;
    return p / (longint'(1) <<< 43);
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(longint x);
    if (x > SAMPLE_MAX) return SMP_W'(SAMPLE_MAX);
    if (x < SAMPLE_MIN) return SMP_W'(SAMPLE_MIN);
    return x[SMP_W-1:0];
  endfunction

  task automatic mixer_regs_reset();
    master_q = GAIN_W'(GAIN_RESET);
    for (int i = 0; i < NUM_V; i++) begin
      gain_q[i] = GAIN_W'(GAIN_RESET);
      pan_q[i]  = '0;
    end
    acc_l = '0;
    acc_r = '0;
  endtask

  // gains clamp to 2.0, pans to [-1, +1]; the spare index is ignored
  task automatic mixer_reg_write(logic [REG_IW-1:0] idx, logic [GAIN_W-1:0] val);
    logic [GAIN_W-1:0]        u;
    logic signed [GAIN_W-1:0] s;
    u = (val > GAIN_MAX) ? GAIN_W'(GAIN_MAX) : val;
    s = signed'(val);
    if (s > PAN_MAX) s = GAIN_W'(PAN_MAX);
    if (s < -PAN_MAX) s = GAIN_W'(-PAN_MAX);
    if (idx == REG_MASTER) master_q = u;
    else if (idx >= REG_GAIN0 && idx < REG_PAN0) gain_q[idx - REG_GAIN0] = u;
    else if (idx < REG_PAN0 + NUM_V) pan_q[idx - REG_PAN0] = s;
  endtask

  // accumulate one voice beat; a closing beat queues the frame it completes
  task automatic mix_beat(logic [VOICE_W-1:0] v, logic signed [SMP_W-1:0] sl,
                          logic signed [SMP_W-1:0] sr, logic last);
    longint amp;
    longint l;
    longint r;
    frame_t f;
    if (v < NUM_V) begin
      amp   = longint'(pan_q[v]) + PAN_MAX;
      l     = pan_scale(sl, gain_q[v], master_q, AMP_ONE - amp);
      r     = pan_scale(sr, gain_q[v], master_q, amp);
      acc_l = sat16(longint'(acc_l) + l);
      acc_r = sat16(longint'(acc_r) + r);
    end
    if (last) begin
      f.left  = acc_l;
      f.right = acc_r;
      pending_frames.push_back(f);
      acc_l = '0;
      acc_r = '0;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_voice(logic [VOICE_W-1:0] v, logic signed [SMP_W-1:0] sl,
                            logic signed [SMP_W-1:0] sr, logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DW - 2*SMP_W - VOICE_W){1'b0}}, sr, sl, v};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mix_beat(v, sl, sr, last);
  endtask

  // drop valid, wait for every frame, then let a trailing beat finish
  task automatic drain_frames();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_valid drops between writes, keeping a single assignment of cfg_valid per step
  task automatic write_reg(logic [REG_IW-1:0] idx, logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mixer_reg_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = drain_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    frame_t exp_f;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        if (fails < 10) $display("unexpected frame out: left %0d right %0d",
                                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
        fails++;
      end else begin
        exp_f = pending_frames.pop_front();
        if (out_tdata[15:0] !== exp_f.left || out_tdata[31:16] !== exp_f.right) begin
          if (fails < 10)
            $display("frame mismatch: left exp %0d got %0d, right exp %0d got %0d",
                     exp_f.left, $signed(out_tdata[15:0]),
                     exp_f.right, $signed(out_tdata[31:16]));
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset values: unity gains, centre pan, so each side is half the sample
  task automatic test_reset_unity();
    send_voice(2'd0, 16'sh7FFF, -16'sh8000, 1'b0);
    send_voice(2'd1, -16'sh8000, 16'sh7FFF, 1'b0);
    send_voice(2'd2, 16'sd1, -16'sd1, 1'b1);
    // silent frame: one zero beat that closes it
    send_voice(2'd0, 16'sd0, 16'sd0, 1'b1);
    drain_frames();
  endtask

  // gains at 2.0, hard pans, and both saturation directions
  task automatic test_extreme_gain_pan();
    write_reg(REG_MASTER, 16'd32768);
    write_reg(REG_IW'(REG_GAIN0 + 0), 16'd32768);
    write_reg(REG_IW'(REG_GAIN0 + 1), 16'd32768);
    write_reg(REG_IW'(REG_GAIN0 + 2), 16'd0);
    write_reg(REG_IW'(REG_PAN0 + 0), -16'sd16384);
    write_reg(REG_IW'(REG_PAN0 + 1), 16'sd16384);
    write_reg(REG_IW'(REG_PAN0 + 2), 16'sd0);
    send_voice(2'd0, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_voice(2'd1, -16'sh8000, -16'sh8000, 1'b0);
    send_voice(2'd2, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_voice(2'd0, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_voice(2'd0, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_voice(2'd0, -16'sh8000, -16'sh8000, 1'b0);
    send_voice(2'd0, -16'sh8000, -16'sh8000, 1'b1);
    drain_frames();
  endtask

  // writes beyond range clamp; the spare index changes nothing
  task automatic test_register_clamps();
    write_reg(REG_MASTER, 16'hFFFF);
    write_reg(REG_IW'(REG_GAIN0 + 0), 16'h8001);
    write_reg(REG_IW'(REG_GAIN0 + 1), 16'd0);
    write_reg(REG_IW'(REG_GAIN0 + 2), 16'd16384);
    write_reg(REG_IW'(REG_PAN0 + 0), 16'h7FFF);
    write_reg(REG_IW'(REG_PAN0 + 1), 16'h8000);
    write_reg(REG_IW'(REG_PAN0 + 2), 16'hC000);
    write_reg(REG_SPARE, 16'h1234);
    send_voice(2'd0, 16'sh4000, -16'sh3000, 1'b1);
    send_voice(2'd1, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_voice(2'd2, -16'sh1234, 16'sh5678, 1'b1);
    drain_frames();
    write_reg(REG_MASTER, 16'd0);
    send_voice(2'd0, 16'sh7FFF, -16'sh8000, 1'b1);
    drain_frames();
  endtask

  // an absent voice adds nothing but still closes the frame
  task automatic test_absent_voice();
    write_reg(REG_MASTER, GAIN_W'(GAIN_RESET));
    send_voice(VOICE_ABSENT, 16'sh7FFF, -16'sh8000, 1'b0);
    send_voice(2'd0, 16'sh2000, 16'sh2000, 1'b1);
    send_voice(2'd2, -16'sh2000, 16'sh1000, 1'b0);
    send_voice(VOICE_ABSENT, -16'sh8000, 16'sh7FFF, 1'b1);
    send_voice(VOICE_ABSENT, 16'sh0F0F, 16'shF0F0, 1'b1);
    drain_frames();
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return '0;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_reg_value(logic [REG_IW-1:0] idx);
    logic [GAIN_W-1:0] r;
    r = GAIN_W'($urandom());
    case ($urandom_range(0, 4))
      0: return (idx < REG_PAN0) ? GAIN_W'(0) : GAIN_W'(-PAN_MAX);
      1: return (idx < REG_PAN0) ? GAIN_W'(GAIN_MAX) : GAIN_W'(PAN_MAX);
      2: return r;
      default: return (idx < REG_PAN0) ? GAIN_W'($urandom_range(0, GAIN_MAX))
                                       : GAIN_W'($urandom_range(0, 2*PAN_MAX) - PAN_MAX);
    endcase
  endfunction

  // phases of mostly well-formed frames, each under fresh settings and idling
  task automatic test_random_frames();
    int sent;
    int n;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int i = 0; i < REG_PAN0 + NUM_V; i++)
        write_reg(REG_IW'(i), pick_reg_value(REG_IW'(i)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, GAIN_W'($urandom()));
      send_idle  = (ph % 3) != 1;
      drain_idle = (ph % 3) != 2;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any voice, any flag
          send_voice(VOICE_W'($urandom_range(0, 3)), pick_sample(), pick_sample(),
                     1'($urandom_range(0, 1)));
          sent++;
        end else begin
          n = $urandom_range(1, 3);
          for (int k = 0; k < n; k++)
            send_voice(VOICE_W'($urandom_range(0, NUM_V - 1)), pick_sample(), pick_sample(),
                       k == n - 1);
          sent += n;
        end
      end
      drain_frames();
    end
    send_idle  = 1'b1;
    drain_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    fails      = 0;
    send_idle  = 1'b1;
    drain_idle = 1'b1;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    mixer_regs_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_unity();
    test_extreme_gain_pan();
    test_register_clamps();
    test_absent_voice();
    test_random_frames();

    drain_frames();
    fails += pending_frames.size();
    if (fails == 0) begin
      $display("stereo_voice_mixer_pan_gain test passed");
    end else begin
      $display("stereo_voice_mixer_pan_gain test failed");
    end
    $finish;
  end

endmodule
